/* rtl/exbfr_pkg.sv */
package exbfr_pkg;

  localparam int MAX_OUT   = 16;
  localparam int IDX_W     = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [7:0] RST_CHANNEL_HEADER    = 8'd62;
  localparam logic [7:0] RST_REQUEST_HEADER    = 8'd61;
  localparam logic [7:0] RST_CHANNEL_DATA_ID   = 8'd49;
  localparam logic [7:0] RST_TELEMETRY_DATA_ID = 8'd58;
  localparam logic [7:0] RST_RESPONSE_ENABLED  = 8'd1;
  localparam logic [7:0] RST_REPLY_HEADER      = 8'd59;

  localparam logic [7:0]       REPLY_LEN_BYTE = 8'd8;
  localparam logic [IDX_W-1:0] REPLY_CRC_POS  = 4'd6;
  localparam logic [IDX_W-1:0] REPLY_LAST_POS = 4'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_HEADER    = 3'd0,
    REG_REQUEST_HEADER    = 3'd1,
    REG_CHANNEL_DATA_ID   = 3'd2,
    REG_TELEMETRY_DATA_ID = 3'd3,
    REG_RESPONSE_ENABLED  = 3'd4,
    REG_REPLY_HEADER      = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_REPLY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_CHECK,
    ST_CH_LO,
    ST_CH_HI,
    ST_CH_OUT,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic [7:0] channel_header;
    logic [7:0] request_header;
    logic [7:0] channel_data_id;
    logic [7:0] telemetry_data_id;
    logic [7:0] response_enabled;
    logic [7:0] reply_header;
  } cfg_t;

  typedef struct packed {
    logic  take;
    logic  rd_lo;
    logic  rd_hi;
    logic  cap_lo;
    logic  idx_clr;
    logic  idx_inc;
    logic  crc_clr;
    logic  emit;
    kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic done;
    logic ch_ok;
    logic rq_ok;
    logic ch_last;
    logic rp_last;
    logic slot_free;
  } dp_status_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] d;
    d = b ^ crc[7:0];
    d = d ^ {d[3:0], 4'h0};
    return {d, crc[15:8]} ^ {12'h000, d[7:4]} ^ {5'b00000, d, 3'b000};
  endfunction

endpackage

/* rtl/exbfr_byte_if.sv */
interface exbfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/exbfr_result_if.sv */
interface exbfr_result_if import exbfr_pkg::*;;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [3:0]  item_index;
  logic [15:0] item_value;
  logic        last;

  modport source (output valid, output kind, output item_index, output item_value,
                  output last, input ready);
  modport sink (input valid, input kind, input item_index, input item_value,
                input last, output ready);
endinterface

/* rtl/exbfr_cfg_if.sv */
interface exbfr_cfg_if import exbfr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/exbfr_ram.sv */
module exbfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/exbfr_ctrl.sv */
module exbfr_ctrl import exbfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.kind   = KIND_ERROR;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (st.err) begin
            state_next = ST_ERR;
          end else if (st.done) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_ERR: begin
        cmd.emit = 1'b1;
        cmd.kind = KIND_ERROR;
        if (st.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CHECK: begin
        priority if (st.ch_ok) begin
          cmd.idx_clr = 1'b1;
          state_next  = ST_CH_LO;
        end else if (st.rq_ok) begin
          cmd.idx_clr = 1'b1;
          cmd.crc_clr = 1'b1;
          state_next  = ST_REPLY;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CH_LO: begin
        cmd.rd_lo  = 1'b1;
        state_next = ST_CH_HI;
      end
      ST_CH_HI: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_hi  = 1'b1;
        state_next = ST_CH_OUT;
      end
      ST_CH_OUT: begin
        cmd.emit = 1'b1;
        cmd.kind = KIND_CHANNEL;
        if (st.slot_free) begin
          if (st.ch_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = ST_CH_LO;
          end
        end
      end
      ST_REPLY: begin
        cmd.emit = 1'b1;
        cmd.kind = KIND_REPLY;
        if (st.slot_free) begin
          if (st.rp_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/exbfr_dp.sv */
module exbfr_dp import exbfr_pkg::*; #(
  parameter int FRAME_BYTES  = 64,
  parameter int NUM_CHANNELS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  dp_cmd_t    cmd,
  output dp_status_t st,
  exbfr_cfg_if.sink      cfg,
  exbfr_result_if.source res
);

  localparam int AW  = $clog2(FRAME_BYTES);
  localparam int CW  = $clog2(FRAME_BYTES + 1);
  localparam int NCH = (NUM_CHANNELS < MAX_OUT) ? NUM_CHANNELS : MAX_OUT;

  cfg_t creg;

  logic          receiving;
  logic [CW-1:0] count;
  logic [7:0]    b0, b1, len, b3, b4, dlen;
  logic [7:0]    p1, p2;
  logic [15:0]   crc;
  logic [7:0]    want_lo, want_hi;
  logic [IDX_W-1:0] idx;
  logic [7:0]    wlo;

  logic          out_valid;
  kind_t         out_kind;
  logic [3:0]    out_index;
  logic [15:0]   out_value;
  logic          out_last;

  logic          hdr_hit, store_ok, frame_done, slot_free, rp_adv;
  logic [CW-1:0] count_inc;
  logic [7:0]    len_eff;
  logic [8:0]    pos, kpos;
  logic [7:0]    addr_lo, addr_hi;
  logic          chan_ok, lo_ok, hi_ok;
  logic [7:0]    rdata, whi, rbyte;
  logic [15:0]   word;
  logic [18:0]   word5;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      creg.channel_header    <= RST_CHANNEL_HEADER;
      creg.request_header    <= RST_REQUEST_HEADER;
      creg.channel_data_id   <= RST_CHANNEL_DATA_ID;
      creg.telemetry_data_id <= RST_TELEMETRY_DATA_ID;
      creg.response_enabled  <= RST_RESPONSE_ENABLED;
      creg.reply_header      <= RST_REPLY_HEADER;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CHANNEL_HEADER:    creg.channel_header    <= cfg.data;
        REG_REQUEST_HEADER:    creg.request_header    <= cfg.data;
        REG_CHANNEL_DATA_ID:   creg.channel_data_id   <= cfg.data;
        REG_TELEMETRY_DATA_ID: creg.telemetry_data_id <= cfg.data;
        REG_RESPONSE_ENABLED:  creg.response_enabled  <= cfg.data;
        REG_REPLY_HEADER:      creg.reply_header      <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // receive path
  assign hdr_hit    = !receiving && (rx_byte == creg.channel_header ||
                                     rx_byte == creg.request_header);
  assign store_ok   = receiving && (count < CW'(FRAME_BYTES));
  assign count_inc  = count + 1'b1;
  assign len_eff    = (count == CW'(2)) ? rx_byte : len;
  assign frame_done = store_ok && (count_inc >= CW'(3)) && (len_eff == 8'(count_inc));
  assign pos        = 9'd6 + 9'({dlen[7:1], 1'b0});
  assign kpos       = 9'(count);

  assign ram_we    = cmd.take && (hdr_hit || store_ok);
  assign ram_waddr = hdr_hit ? '0 : count[AW-1:0];

  assign slot_free = !out_valid || res.ready;
  assign rp_adv    = cmd.emit && slot_free && (cmd.kind == KIND_REPLY) && (idx < REPLY_CRC_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving <= 1'b0;
      count     <= '0;
      crc       <= '0;
    end else if (cmd.take) begin
      if (hdr_hit) begin
        receiving <= 1'b1;
        count     <= CW'(1);
        b0        <= rx_byte;
        b1        <= '0;
        len       <= '0;
        b3        <= '0;
        b4        <= '0;
        dlen      <= '0;
        want_lo   <= '0;
        want_hi   <= '0;
        p1        <= rx_byte;
        p2        <= '0;
        crc       <= '0;
      end else if (store_ok) begin
        count <= count_inc;
        if (count == CW'(1)) begin
          b1 <= rx_byte;
        end
        if (count == CW'(2)) begin
          len <= rx_byte;
        end
        if (count == CW'(3)) begin
          b3 <= rx_byte;
        end
        if (count == CW'(4)) begin
          b4 <= rx_byte;
        end
        if (count == CW'(5)) begin
          dlen <= rx_byte;
        end
        if (count >= CW'(6) && kpos == pos) begin
          want_lo <= rx_byte;
        end
        if (count >= CW'(6) && kpos == pos + 9'd1) begin
          want_hi <= rx_byte;
        end
        // CRC trails the stream by two bytes, so it stops before the CRC word
        if (count >= CW'(2)) begin
          crc <= crc_step(crc, p2);
        end
        p2 <= p1;
        p1 <= rx_byte;
        if (frame_done) begin
          receiving <= 1'b0;
        end
      end else begin
        receiving <= 1'b0;
      end
    end else if (cmd.crc_clr) begin
      crc <= '0;
    end else if (rp_adv) begin
      crc <= crc_step(crc, rbyte);
    end
  end

  exbfr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rx_byte),
    .re    (cmd.rd_lo || cmd.rd_hi),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // channel words
  assign addr_lo   = 8'd6 + 8'({idx, 1'b0});
  assign addr_hi   = addr_lo + 8'd1;
  assign chan_ok   = (9'({idx, 1'b0}) + 9'd2) <= {1'b0, dlen};
  assign lo_ok     = chan_ok && (addr_lo < len) && (9'(addr_lo) < 9'(FRAME_BYTES));
  assign hi_ok     = chan_ok && (addr_hi < len) && (9'(addr_hi) < 9'(FRAME_BYTES));
  assign ram_raddr = cmd.rd_hi ? addr_hi[AW-1:0] : addr_lo[AW-1:0];
  assign whi       = hi_ok ? rdata : 8'h00;
  assign word      = {whi, wlo};
  assign word5     = {1'b0, word, 2'b00} + {3'b000, word};

  always_ff @(posedge clk) begin
    if (cmd.cap_lo) begin
      wlo <= lo_ok ? rdata : 8'h00;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // reply bytes
  always_comb begin
    unique case (idx)
      4'd0:    rbyte = creg.reply_header;
      4'd1:    rbyte = creg.response_enabled;
      4'd2:    rbyte = REPLY_LEN_BYTE;
      4'd3:    rbyte = b3;
      4'd4:    rbyte = creg.telemetry_data_id;
      4'd6:    rbyte = crc[7:0];
      4'd7:    rbyte = crc[15:8];
      default: rbyte = 8'h00;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit && slot_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && slot_free) begin
      out_kind <= cmd.kind;
      unique case (cmd.kind)
        KIND_CHANNEL: begin
          out_index <= idx;
          out_value <= word5[18:3];
          out_last  <= st.ch_last;
        end
        KIND_REPLY: begin
          out_index <= idx;
          out_value <= {8'h00, rbyte};
          out_last  <= st.rp_last;
        end
        default: begin
          out_index <= '0;
          out_value <= '0;
          out_last  <= 1'b1;
        end
      endcase
    end
  end

  assign res.valid      = out_valid;
  assign res.kind       = out_kind;
  assign res.item_index = out_index;
  assign res.item_value = out_value;
  assign res.last       = out_last;

  // status
  assign st.err       = !hdr_hit && !store_ok;
  assign st.done      = frame_done;
  assign st.ch_ok     = (crc == {want_hi, want_lo}) && (b0 == creg.channel_header) &&
                        (b4 == creg.channel_data_id);
  assign st.rq_ok     = (crc == {want_hi, want_lo}) && (b0 == creg.request_header) &&
                        (b4 == creg.telemetry_data_id) && (b1 == creg.response_enabled);
  assign st.ch_last   = (idx == IDX_W'(NCH - 1));
  assign st.rp_last   = (idx == REPLY_LAST_POS);
  assign st.slot_free = slot_free;

endmodule

/* rtl/ex_bus_frame_receiver.sv */
// Serial radio-control bus frame receiver.
// rx: one received byte per word, taken only while the receiver is idle;
//   a byte that does not finish a frame or hit an error leaves it idle.
// cfg: header, data id and reply codes, always ready; write only while idle.
// res: result words (channel value, reply byte or framing error), with last
//   set on the final word caused by one byte, held in one output register.
// A byte in the wrong place gives one error word, via the error state.
// A byte that completes a frame passes through a check state, then either
//   the channel words, each from two reads of the frame RAM and one output
//   slot, up to 16 words, or the 8 reply bytes, or nothing if the checks fail.
//   Input stays stalled until the last word of that burst is in the output
//   register; a stalled res holds the sequencer on the current word.
// The frame store is a single-port-write, registered-read RAM of
// FRAME_BYTES bytes; its reads are what set the channel word rate.
// Reset (rst, synchronous) returns to waiting for a header, drops any
// pending word and reloads the register defaults; the RAM keeps its data.
module ex_bus_frame_receiver import exbfr_pkg::*; #(
  parameter int FRAME_BYTES  = 64,
  parameter int NUM_CHANNELS = 16
) (
  input logic            clk,
  input logic            rst,
  exbfr_cfg_if.sink      cfg,
  exbfr_byte_if.sink     rx,
  exbfr_result_if.source res
);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       in_ready;

  exbfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  assign rx.ready = in_ready;

  exbfr_dp #(
    .FRAME_BYTES  (FRAME_BYTES),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (rx.rx_byte),
    .cmd     (cmd),
    .st      (st),
    .cfg     (cfg),
    .res     (res)
  );

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == KIND_ERROR) |->
      (res.last && res.item_index == 4'd0 && res.item_value == 16'd0))
    else $error("error word with nonzero fields");

  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == KIND_CHANNEL) |-> (res.item_value <= 16'd40959))
    else $error("channel value out of range");

  a_burst_holds_input: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && !res.last) |-> !rx.ready)
    else $error("input taken inside a result burst");

endmodule
